// File: hw/rtl/rtttl_pkg.sv
`timescale 1ns / 1ps
package rtttl_pkg;
    localparam int NUMBER_BITS = 16;
    localparam int NUM_W = NUMBER_BITS;
    localparam logic [17:0] WHOLE_TIME = 18'd240000;

    localparam logic [1:0] ST_NOTE = 2'd0;
    localparam logic [1:0] ST_FINISH = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic        start;
        logic [17:0] dividend;
        logic [15:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [17:0] quotient;
    } t_div_sts;

    function automatic logic [15:0] natural_hz(input logic [7:0] c);
        case (c)
            8'h61: natural_hz = 16'd440;
            8'h62: natural_hz = 16'd493;
            8'h63: natural_hz = 16'd523;
            8'h64: natural_hz = 16'd587;
            8'h65: natural_hz = 16'd659;
            8'h66: natural_hz = 16'd698;
            8'h67: natural_hz = 16'd784;
            default: natural_hz = 16'd0;
        endcase
    endfunction

    function automatic logic [15:0] sharp_hz(input logic [7:0] c);
        case (c)
            8'h61: sharp_hz = 16'd466;
            8'h63: sharp_hz = 16'd554;
            8'h64: sharp_hz = 16'd622;
            8'h66: sharp_hz = 16'd740;
            8'h67: sharp_hz = 16'd830;
            default: sharp_hz = 16'd0;
        endcase
    endfunction
endpackage

// File: hw/rtl/rtttl_div.sv
`timescale 1ns / 1ps
module rtttl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtttl_pkg::t_div_cmd i_cmd,
    output rtttl_pkg::t_div_sts o_sts
);
    import rtttl_pkg::*;

    logic [17:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [17:0] w_trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[17]} - {2'd0, r_den};
        n_quo = {r_quo[16:0], 1'b0};
        n_rem = {r_rem[15:0], r_quo[17]};
        if (!w_trial[17]) begin
            n_quo[0] = 1'b1;
            n_rem = w_trial[16:0];
        end
        n_cnt = r_cnt - 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd18;
                r_quo  <= i_cmd.dividend;
                r_rem  <= '0;
                r_den  <= i_cmd.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.quotient = r_quo;
endmodule

// File: hw/rtl/rtttl_ctrl.sv
`timescale 1ns / 1ps
module rtttl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_end_of_text,
    output rtttl_pkg::t_div_cmd o_div_cmd,
    input  rtttl_pkg::t_div_sts i_div_sts,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [15:0]       o_frequency_hz,
    output logic [19:0]       o_duration_ms,
    output logic              o_last_of_run
);
    import rtttl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TDIV  = 5'b00010,
        S_NDIV  = 5'b00100,
        S_DOTS  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    localparam logic [2:0] PH_TITLE = 3'd0, PH_KEY = 3'd1, PH_EQ = 3'd2,
        PH_VALUE = 3'd3, PH_NOTES = 3'd4, PH_DRAIN = 3'd5;
    localparam logic [2:0] NS_START = 3'd0, NS_DIV = 3'd1, NS_LETTER = 3'd2,
        NS_DOT1 = 3'd3, NS_OCT0 = 3'd4, NS_OCT = 3'd5, NS_DOT2 = 3'd6,
        NS_SEP = 3'd7;

    t_state r_state;
    logic [2:0]  r_phase, r_nstage;
    logic [1:0]  r_key, r_dots, r_dcnt;
    logic [NUM_W-1:0] r_acc;
    logic [15:0] r_ddiv, r_tempo, r_ndiv, r_base;
    logic [3:0]  r_doct, r_oct;
    logic [17:0] r_whole;
    logic [7:0]  r_letter;
    // pending emissions: note then (end) finished/error
    logic        r_emit_note, r_emit_end, r_end_err, r_end_has_note, r_end_reset;
    logic [7:0]  r_c;
    logic        r_redo;
    logic        r_end;
    logic [19:0] r_dur;
    logic [15:0] r_freq;
    logic        r_oval;
    logic [1:0]  r_ostat;
    logic [15:0] r_ofreq;
    logic [19:0] r_odur;
    logic        r_olast;

    logic [NUM_W+3:0] w_mul;
    logic [NUM_W-1:0] w_acc_next;
    logic             w_dig;
    logic [15:0]      w_acc16;
    logic [3:0]       w_acc4;

    always_comb begin
        w_dig = (r_c >= 8'h30) && (r_c <= 8'h39);
        w_mul = {4'd0, r_acc} * (NUM_W + 4)'(10) + (NUM_W + 4)'(r_c - 8'h30);
        w_acc_next = (w_mul > (NUM_W + 4)'({NUM_W{1'b1}})) ? {NUM_W{1'b1}}
                                                          : w_mul[NUM_W-1:0];
        w_acc16 = ({{(32-NUM_W){1'b0}}, r_acc} > 32'd65535) ? 16'hFFFF
                                                             : 16'(r_acc);
        w_acc4 = ({{(32-NUM_W){1'b0}}, r_acc} > 32'd15) ? 4'd15 : 4'(r_acc);
    end

    assign o_ready = (r_state == S_IDLE) && !r_oval && !r_redo
                     && !r_emit_note && !r_emit_end && !r_end && !r_end_reset;
    assign o_valid = r_oval;
    assign o_status = r_ostat;
    assign o_frequency_hz = r_ofreq;
    assign o_duration_ms = r_odur;
    assign o_last_of_run = r_olast;

    logic [15:0] w_freq;
    always_comb begin
        w_freq = r_base;
        for (int k = 5; k <= 15; k++)
            if (32'(r_oct) >= k) w_freq = {w_freq[14:0], 1'b0};
    end

    logic w_take;
    assign w_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        o_div_cmd.start <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_TITLE; r_nstage <= NS_START; r_key <= '0; r_acc <= '0;
            r_ddiv <= 16'd4; r_doct <= 4'd6; r_tempo <= 16'd63;
            r_whole <= 18'd3809; r_letter <= '0; r_base <= '0; r_ndiv <= '0;
            r_oct <= '0; r_dots <= '0;
            r_emit_note <= 1'b0; r_emit_end <= 1'b0; r_end_err <= 1'b0;
            r_end_has_note <= 1'b0; r_end_reset <= 1'b0; r_redo <= 1'b0;
            r_end <= 1'b0; r_oval <= 1'b0;
            o_div_cmd.dividend <= '0; o_div_cmd.divisor <= '0;
        end else begin
            if (r_oval && i_ready) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_c <= i_char_code;
                        r_end <= i_end_of_text;
                        if (r_phase != PH_DRAIN) r_redo <= 1'b1;
                    end else if (r_end_reset) begin
                        r_end_reset <= 1'b0;
                        r_phase <= PH_TITLE; r_nstage <= NS_START; r_key <= '0;
                        r_acc <= '0; r_ddiv <= 16'd4; r_doct <= 4'd6;
                        r_tempo <= 16'd63; r_whole <= 18'd3809; r_letter <= '0;
                        r_base <= '0; r_ndiv <= '0; r_oct <= '0; r_dots <= '0;
                    end else if (r_emit_note && !r_oval) begin
                        // compute note then emit as note or finished, or as error if the divisor is zero
                        r_state <= S_NDIV;
                        o_div_cmd.start <= 1'b1;
                        o_div_cmd.dividend <= r_whole;
                        o_div_cmd.divisor <= r_ndiv;
                        r_freq <= w_freq;
                    end else if (r_emit_end && !r_oval) begin
                        r_emit_end <= 1'b0;
                        r_oval <= 1'b1;
                        r_ostat <= r_end_err ? ST_ERROR : ST_FINISH;
                        r_ofreq <= '0; r_odur <= '0; r_olast <= 1'b1;
                    end else if (r_redo) begin
                        // one parse step on r_c; repeats until consumed
                        r_redo <= 1'b0;
                        case (r_phase)
                            PH_TITLE: if (r_c == 8'h3A) r_phase <= PH_KEY;
                            PH_KEY: begin
                                if (r_c == 8'h3A) begin
                                    if (r_tempo == 16'd0) begin
                                        r_phase <= PH_DRAIN; r_emit_end <= 1'b1;
                                        r_end_err <= 1'b1;
                                    end else begin
                                        r_state <= S_TDIV;
                                        o_div_cmd.start <= 1'b1;
                                        o_div_cmd.dividend <= WHOLE_TIME;
                                        o_div_cmd.divisor <= r_tempo;
                                    end
                                end else if (r_c == 8'h64 || r_c == 8'h6F
                                             || r_c == 8'h62 || r_c == 8'h6C) begin
                                    r_key <= (r_c == 8'h64) ? 2'd0 :
                                             (r_c == 8'h6F) ? 2'd1 :
                                             (r_c == 8'h62) ? 2'd2 : 2'd3;
                                    r_phase <= PH_EQ;
                                end else begin
                                    r_phase <= PH_DRAIN; r_emit_end <= 1'b1;
                                    r_end_err <= 1'b1;
                                end
                            end
                            PH_EQ: begin
                                if (r_c != 8'h3D) begin
                                    r_phase <= PH_DRAIN; r_emit_end <= 1'b1;
                                    r_end_err <= 1'b1;
                                end else begin
                                    r_acc <= '0; r_phase <= PH_VALUE;
                                end
                            end
                            PH_VALUE: begin
                                if (w_dig) r_acc <= w_acc_next;
                                else begin
                                    if (r_key == 2'd0) r_ddiv <= w_acc16;
                                    else if (r_key == 2'd1) r_doct <= w_acc4;
                                    else if (r_key == 2'd2) r_tempo <= w_acc16;
                                    r_phase <= PH_KEY;
                                    if (r_c != 8'h2C) r_redo <= 1'b1;
                                end
                            end
                            default: begin
                                case (r_nstage)
                                    NS_START: begin
                                        r_ndiv <= r_ddiv; r_oct <= r_doct;
                                        r_dots <= '0;
                                        if (w_dig) begin
                                            r_acc <= NUM_W'(r_c - 8'h30);
                                            r_nstage <= NS_DIV;
                                        end else begin
                                            r_letter <= r_c;
                                            r_base <= natural_hz(r_c);
                                            r_nstage <= NS_LETTER;
                                        end
                                    end
                                    NS_DIV: begin
                                        if (w_dig) r_acc <= w_acc_next;
                                        else begin
                                            r_ndiv <= w_acc16;
                                            r_letter <= r_c;
                                            r_base <= natural_hz(r_c);
                                            r_nstage <= NS_LETTER;
                                        end
                                    end
                                    NS_LETTER: begin
                                        r_nstage <= NS_DOT1;
                                        if (r_c == 8'h23) r_base <= sharp_hz(r_letter);
                                        else r_redo <= 1'b1;
                                    end
                                    NS_DOT1: begin
                                        r_nstage <= NS_OCT0;
                                        if (r_c == 8'h2E) r_dots <= 2'd1;
                                        else r_redo <= 1'b1;
                                    end
                                    NS_OCT0: begin
                                        if (w_dig) begin
                                            r_acc <= NUM_W'(r_c - 8'h30);
                                            r_nstage <= NS_OCT;
                                        end else begin
                                            r_nstage <= NS_DOT2;
                                            r_redo <= 1'b1;
                                        end
                                    end
                                    NS_OCT: begin
                                        if (w_dig) r_acc <= w_acc_next;
                                        else begin
                                            r_oct <= w_acc4;
                                            r_nstage <= NS_DOT2;
                                            r_redo <= 1'b1;
                                        end
                                    end
                                    NS_DOT2: begin
                                        r_nstage <= NS_SEP;
                                        if (r_c == 8'h2E) begin
                                            if (r_dots != 2'd3) r_dots <= r_dots + 2'd1;
                                        end else r_redo <= 1'b1;
                                    end
                                    default: begin
                                        // emit note; redo char afterwards unless it is a comma
                                        r_emit_note <= 1'b1;
                                        r_end_has_note <= 1'b0;
                                        r_nstage <= NS_START;
                                        if (r_c != 8'h2C) r_redo <= 1'b1;
                                    end
                                endcase
                            end
                        endcase
                    end else if (r_end) begin
                        // end of text handling after char consumed
                        r_end <= 1'b0;
                        if (r_phase == PH_NOTES) begin
                            if (r_nstage == NS_START) begin
                                r_emit_end <= 1'b1; r_end_err <= 1'b0;
                                r_end_reset <= 1'b1;
                            end else if (r_nstage == NS_DIV) begin
                                r_emit_end <= 1'b1; r_end_err <= 1'b1;
                                r_end_reset <= 1'b1;
                            end else begin
                                if (r_nstage == NS_OCT) r_oct <= w_acc4;
                                r_emit_note <= 1'b1; r_end_has_note <= 1'b1;
                            end
                        end else if (r_phase == PH_DRAIN) begin
                            r_end_reset <= 1'b1;
                        end else begin
                            r_emit_end <= 1'b1; r_end_err <= 1'b1;
                            r_end_reset <= 1'b1;
                        end
                    end
                end
                S_TDIV: begin
                    if (i_div_sts.done) begin
                        r_whole <= i_div_sts.quotient;
                        r_phase <= PH_NOTES;
                        r_nstage <= NS_START;
                        r_state <= S_IDLE;
                    end
                end
                S_NDIV: begin
                    if (r_ndiv == 16'd0) begin
                        r_emit_note <= 1'b0;
                        r_state <= S_IDLE;
                        r_redo <= 1'b0;
                        r_phase <= PH_DRAIN;
                        r_emit_end <= 1'b1; r_end_err <= 1'b1;
                        if (r_end_has_note) r_end_reset <= 1'b1;
                        r_end_has_note <= 1'b0;
                    end else if (i_div_sts.done) begin
                        r_dur <= {2'd0, i_div_sts.quotient};
                        r_dcnt <= r_dots;
                        r_state <= S_DOTS;
                    end
                end
                S_DOTS: begin
                    if (r_dcnt != 2'd0) begin
                        r_dur <= r_dur + {1'b0, r_dur[19:1]};
                        r_dcnt <= r_dcnt - 2'd1;
                    end else begin
                        r_emit_note <= 1'b0;
                        r_oval <= 1'b1;
                        r_ofreq <= r_freq;
                        r_odur <= r_dur;
                        r_ostat <= r_end_has_note ? ST_FINISH : ST_NOTE;
                        r_olast <= r_end_has_note || !r_end;
                        if (r_end_has_note) begin
                            r_end_reset <= 1'b1;
                            r_end_has_note <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/rtttl_note_decoder.sv
`timescale 1ns / 1ps
// a title or header character needs only parse steps; a closing ':' also waits
// for the 18-step serial divider and its handoff
// a character that completes a note passes through parse steps, the divider
// and up to 3 dot steps; an end-of-text transaction may complete two notes
// throughput: one transaction at a time, stalled while a result waits on the output
// reset: synchronous active low; defaults d=4, o=6, b=63, also after each end of text
module rtttl_note_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_frequency_hz,
    output logic [19:0] o_duration_ms,
    output logic        o_last_of_run
);
    import rtttl_pkg::*;

    t_div_cmd w_cmd;
    t_div_sts w_sts;

    rtttl_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_char_code, .i_end_of_text,
        .o_div_cmd(w_cmd), .i_div_sts(w_sts), .o_valid, .i_ready, .o_status,
        .o_frequency_hz, .o_duration_ms, .o_last_of_run
    );

    rtttl_div u_div (.i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts));
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import rtttl_pkg::*;

    localparam int PH_TITLE = 0, PH_KEY = 1, PH_EQ = 2, PH_VALUE = 3, PH_NOTES = 4,
                   PH_DRAIN = 5;
    localparam int NS_START = 0, NS_DIV = 1, NS_LETTER = 2, NS_DOT1 = 3, NS_OCT0 = 4,
                   NS_OCT = 5, NS_DOT2 = 6, NS_SEP = 7;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] freq;
        logic [19:0] dur;
        logic        last;
    } note_result_t;

    // ringtone parser model plus queue of pending notes
    class note_scoreboard;
        int phase, key, stage;
        longint unsigned accum;
        int unsigned def_div, def_oct, tempo, whole, letter, base_hz, div, oct, dots;
        note_result_t pending[$];
        note_result_t run[$];
        int mismatches;
        int notes_seen;

        function void clear_state();
            phase = PH_TITLE; key = 0; accum = 0; def_div = 4; def_oct = 6;
            tempo = 63; whole = 240000 / 63; letter = 0; base_hz = 0; div = 0;
            oct = 0; dots = 0; stage = NS_START;
        endfunction

        function void add_result(int st, int unsigned f, int unsigned d);
            note_result_t r;
            if (run.size() >= 2) return;
            r.status = st[1:0]; r.freq = f[15:0]; r.dur = d[19:0]; r.last = 1'b0;
            run.push_back(r);
        endfunction

        function void push_digit(int unsigned c);
            accum = accum * 10 + (c - 48);
            if (accum > 65535) accum = 65535;
        endfunction

        function int unsigned plain_hz(int unsigned c);
            case (c)
                97: return 440; 98: return 493; 99: return 523; 100: return 587;
                101: return 659; 102: return 698; 103: return 784;
                default: return 0;
            endcase
        endfunction

        function int unsigned raised_hz(int unsigned c);
            case (c)
                97: return 466; 99: return 554; 100: return 622; 102: return 740;
                103: return 830;
                default: return 0;
            endcase
        endfunction

        function bit note_timing(output int unsigned f, output int unsigned d);
            if (div == 0) return 0;
            f = base_hz;
            for (int k = 4; k < oct; k++) f = (f << 1) & 32'hffff;
            d = whole / div;
            for (int k = 0; k < dots; k++) d += d / 2;
            d &= 32'hfffff;
            return 1;
        endfunction

        function bit is_num(int unsigned c);
            return c >= 48 && c <= 57;
        endfunction

        function bit step_note(int unsigned c);
            int unsigned f, d;
            forever begin
                case (stage)
                    NS_START: begin
                        div = def_div; oct = def_oct; dots = 0; base_hz = 0;
                        if (is_num(c)) begin
                            accum = 0; push_digit(c); stage = NS_DIV;
                        end else begin
                            letter = c; base_hz = plain_hz(c); stage = NS_LETTER;
                        end
                        return 1;
                    end
                    NS_DIV: begin
                        if (is_num(c)) begin
                            push_digit(c);
                            return 1;
                        end
                        div = accum;
                        letter = c; base_hz = plain_hz(c); stage = NS_LETTER;
                        return 1;
                    end
                    NS_LETTER: begin
                        stage = NS_DOT1;
                        if (c == 35) begin
                            base_hz = raised_hz(letter);
                            return 1;
                        end
                    end
                    NS_DOT1: begin
                        stage = NS_OCT0;
                        if (c == 46) begin
                            dots = 1;
                            return 1;
                        end
                    end
                    NS_OCT0: begin
                        if (is_num(c)) begin
                            accum = 0; push_digit(c); stage = NS_OCT;
                            return 1;
                        end
                        stage = NS_DOT2;
                    end
                    NS_OCT: begin
                        if (is_num(c)) begin
                            push_digit(c);
                            return 1;
                        end
                        oct = accum > 15 ? 15 : accum;
                        stage = NS_DOT2;
                    end
                    NS_DOT2: begin
                        stage = NS_SEP;
                        if (c == 46) begin
                            if (dots < 3) dots++;
                            return 1;
                        end
                    end
                    default: begin
                        if (!note_timing(f, d)) begin
                            add_result(ST_ERROR, 0, 0);
                            return 0;
                        end
                        add_result(ST_NOTE, f, d);
                        stage = NS_START;
                        if (c == 44) return 1;
                    end
                endcase
            end
        endfunction

        function bit step_char(int unsigned c);
            forever begin
                case (phase)
                    PH_TITLE: begin
                        if (c == 58) phase = PH_KEY;
                        return 1;
                    end
                    PH_KEY: begin
                        if (c == 58) begin
                            if (tempo == 0) begin
                                add_result(ST_ERROR, 0, 0);
                                return 0;
                            end
                            whole = 240000 / tempo;
                            phase = PH_NOTES; stage = NS_START;
                            return 1;
                        end
                        if (c == 100) key = 0;
                        else if (c == 111) key = 1;
                        else if (c == 98) key = 2;
                        else if (c == 108) key = 3;
                        else begin
                            add_result(ST_ERROR, 0, 0);
                            return 0;
                        end
                        phase = PH_EQ;
                        return 1;
                    end
                    PH_EQ: begin
                        if (c != 61) begin
                            add_result(ST_ERROR, 0, 0);
                            return 0;
                        end
                        accum = 0; phase = PH_VALUE;
                        return 1;
                    end
                    PH_VALUE: begin
                        if (is_num(c)) begin
                            push_digit(c);
                            return 1;
                        end
                        if (key == 0) def_div = accum;
                        else if (key == 1) def_oct = accum > 15 ? 15 : accum;
                        else if (key == 2) tempo = accum;
                        phase = PH_KEY;
                        if (c == 44) return 1;
                    end
                    default: return step_note(c);
                endcase
            end
        endfunction

        function void note_input(logic [7:0] c, logic eot);
            int unsigned f, d;
            run.delete();
            if (phase == PH_DRAIN) begin
                if (eot) clear_state();
                return;
            end
            if (!step_char(c)) phase = PH_DRAIN;
            if (eot) begin
                if (phase == PH_NOTES) begin
                    if (stage == NS_START) add_result(ST_FINISH, 0, 0);
                    else if (stage == NS_DIV) add_result(ST_ERROR, 0, 0);
                    else begin
                        if (stage == NS_OCT) oct = accum > 15 ? 15 : accum;
                        if (!note_timing(f, d)) add_result(ST_ERROR, 0, 0);
                        else add_result(ST_FINISH, f, d);
                    end
                end else if (phase != PH_DRAIN) add_result(ST_ERROR, 0, 0);
                clear_state();
            end
            if (run.size() > 0) run[run.size() - 1].last = 1'b1;
            foreach (run[i]) pending.push_back(run[i]);
        endfunction

        function void check_result(note_result_t got);
            note_result_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result st=%0d f=%0d d=%0d", got.status,
                             got.freq, got.dur);
                return;
            end
            exp = pending.pop_front();
            notes_seen++;
            if (got.status !== exp.status || got.freq !== exp.freq ||
                got.dur !== exp.dur || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d f=%0d d=%0d l=%0d got st=%0d f=%0d d=%0d l=%0d",
                             exp.status, exp.freq, exp.dur, exp.last,
                             got.status, got.freq, got.dur, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_char_code = 8'd0;
    logic i_end_of_text = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_status;
    logic [15:0] o_frequency_hz;
    logic [19:0] o_duration_ms;
    logic o_last_of_run;

    note_scoreboard sb = new();
    int sent = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit hold_off = 0;
    int tunes = 0;
    byte unsigned tune[$];

    rtttl_note_decoder dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one transaction on the character channel
    task send_char(input byte unsigned c, input bit eot);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(c, eot);
        sent++;
        @(negedge i_clk);
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
        tunes++;
    endtask

    task send_tune();
        for (int i = 0; i < tune.size(); i++) send_char(tune[i], i == tune.size() - 1);
        tunes++;
    endtask

    task add_num(input int lo, input int hi);
        string s;
        s.itoa($urandom_range(lo, hi));
        for (int i = 0; i < s.len(); i++) tune.push_back(s[i]);
    endtask

    task build_tune();
        string letters;
        int n;
        letters = "abcdefgpxh";
        tune.delete();
        repeat ($urandom_range(0, 4)) tune.push_back($urandom_range(97, 122));
        tune.push_back(":");
        if ($urandom_range(0, 3) != 0) begin
            tune.push_back("d"); tune.push_back("="); add_num(1, 32); tune.push_back(",");
        end
        if ($urandom_range(0, 3) != 0) begin
            tune.push_back("o"); tune.push_back("="); add_num(0, 9); tune.push_back(",");
        end
        if ($urandom_range(0, 3) != 0) begin
            tune.push_back("b"); tune.push_back("="); add_num(1, 400);
        end
        tune.push_back(":");
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 1)) add_num(1, 64);
            tune.push_back(letters[$urandom_range(0, letters.len() - 1)]);
            if ($urandom_range(0, 2) == 0) tune.push_back("#");
            if ($urandom_range(0, 3) == 0) tune.push_back(".");
            if ($urandom_range(0, 1)) add_num(0, 9);
            if ($urandom_range(0, 3) == 0) tune.push_back(".");
            if (k != n - 1) tune.push_back(",");
        end
        // corrupt a few tunes
        if ($urandom_range(0, 9) == 0)
            tune[$urandom_range(0, tune.size() - 1)] = $urandom_range(0, 255);
    endtask

    always @(posedge i_clk) begin
        note_result_t r;
        if (i_rst_n && o_valid && i_ready) begin
            r.status = o_status; r.freq = o_frequency_hz;
            r.dur = o_duration_ms; r.last = o_last_of_run;
            sb.check_result(r);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int g;
        @(negedge i_clk);
        forever begin
            if (hold_off) i_ready <= 1'b0;
            else if ($urandom_range(0, 9) < 3) begin
                g = gap_len();
                if (g > 0) begin
                    i_ready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                i_ready <= 1'b1;
            end else i_ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    initial begin
        sb.clear_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_text("t:d=4,o=5,b=120:c,8d#6.,32p,a#.,2e#7.,1b4,16g15,x#,9999999f");
        send_text("z:d=65535,o=99,b=99999,l=3:c,1g.8..,f#9,");
        send_text(":d=0:c");
        send_text(":b=0:c");
        send_text(":q=1:c");
        send_text(":d1");
        send_text(":d=4");
        send_text("t:d=8:12");
        send_text("t:b=1:1a15.,64c,");
        send_text("title:");
        send_text({"x:d=4:", 8'd255, ",", 8'd0, ",c", ":"});
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (3) begin
                build_tune();
                send_tune();
            end
        join
        while (sent < 1550) begin
            if ($urandom_range(0, 9) == 0) begin
                tune.delete();
                repeat ($urandom_range(1, 12)) tune.push_back($urandom_range(0, 255));
            end else build_tune();
            send_tune();
        end
        i_valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (100) @(negedge i_clk);
        $display("sent %0d characters in %0d tunes, checked %0d notes", sent, tunes,
                 sb.notes_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
